/* src/tcci_pkg.sv */
// ----------------------------------------------------------------------------
// tcci_pkg
// Shared types, widths, codes and helpers of the temperature-compensated
// curve interpolation unit.
// ----------------------------------------------------------------------------
package tcci_pkg;

    // parameter defaults
    localparam int DEF_TABLE_DEPTH = 64;
    localparam int DEF_CURVES      = 3;
    localparam int DEF_FRAC_BITS   = 16;

    // field widths
    localparam int OP_W    = 1;
    localparam int CURVE_W = 2;
    localparam int IDX_W   = 6;
    localparam int VAL_W   = 32;
    localparam int SEG_W   = 6;
    localparam int LAST_W  = 6;

    // input item packing
    localparam int IN_KEY_LSB   = IDX_W;
    localparam int IN_BASE_LSB  = IN_KEY_LSB + VAL_W;
    localparam int IN_SLOPE_LSB = IN_BASE_LSB + VAL_W;
    localparam int IN_QKEY_LSB  = IN_SLOPE_LSB + VAL_W;
    localparam int IN_TEMP_LSB  = IN_QKEY_LSB + VAL_W;
    localparam int IN_TDATA_W   = ((IN_TEMP_LSB + VAL_W + 7) / 8) * 8;
    localparam int IN_TUSER_W   = OP_W + CURVE_W;

    // result item packing
    localparam int OUT_TDATA_W = ((VAL_W + SEG_W + 7) / 8) * 8;
    localparam int OUT_PAD_W   = OUT_TDATA_W - VAL_W - SEG_W;
    localparam int OUT_TUSER_W = 1;

    // arithmetic widths
    localparam int MUL_W  = VAL_W + 1;      // differences of two 32-bit values
    localparam int PROD_W = 2 * MUL_W;      // full signed product
    localparam int QUOT_W = 41;             // quotient is capped at 2^40

    localparam logic [QUOT_W-1:0] QUOT_CAP = {1'b1, {(QUOT_W-1){1'b0}}};

    // operation codes
    localparam logic [OP_W-1:0] OP_WRITE = 1'b0;
    localparam logic [OP_W-1:0] OP_QUERY = 1'b1;

    // one breakpoint
    typedef struct packed {
        logic signed [VAL_W-1:0] slope;
        logic signed [VAL_W-1:0] base;
        logic signed [VAL_W-1:0] key;
    } entry_t;

    localparam logic signed [PROD_W-1:0] SAT_MAX = PROD_W'(64'sd2147483647);
    localparam logic signed [PROD_W-1:0] SAT_MIN = -SAT_MAX - PROD_W'(64'sd1);

    // clamp a wide signed value to 32 bits
    function automatic logic [VAL_W-1:0] sat32(input logic signed [PROD_W-1:0] v);
        logic [VAL_W-1:0] r;
        if (v > SAT_MAX)
        begin
            r = {1'b0, {(VAL_W-1){1'b1}}};
        end
        else if (v < SAT_MIN)
        begin
            r = {1'b1, {(VAL_W-1){1'b0}}};
        end
        else
        begin
            r = v[VAL_W-1:0];
        end
        return r;
    endfunction

endpackage

/* src/tcci_mem.sv */
// ----------------------------------------------------------------------------
// tcci_mem
// Breakpoint store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module tcci_mem #(
    parameter int DEPTH = tcci_pkg::DEF_CURVES * tcci_pkg::DEF_TABLE_DEPTH
) (
    input  logic                          clk,
    input  logic                          we,
    input  logic [$clog2(DEPTH)-1:0]      waddr,
    input  tcci_pkg::entry_t              wdata,
    input  logic                          re,
    input  logic [$clog2(DEPTH)-1:0]      raddr,
    output tcci_pkg::entry_t              rdata
);

    tcci_pkg::entry_t mem_arr [DEPTH];
    tcci_pkg::entry_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_arr[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_arr[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* src/tcci_div.sv */
// ----------------------------------------------------------------------------
// tcci_div
// Serial restoring divider, one quotient bit per cycle. Quotients of 2^41 and
// above are detected up front; any quotient above the cap is clamped.
// ----------------------------------------------------------------------------
module tcci_div (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic [tcci_pkg::PROD_W-1:0]       dividend,
    input  logic [tcci_pkg::MUL_W-1:0]        divisor,
    output logic                              done,
    output logic [tcci_pkg::QUOT_W-1:0]       quotient
);

    localparam int QW  = tcci_pkg::QUOT_W;
    localparam int DW  = tcci_pkg::MUL_W;
    localparam int HW  = tcci_pkg::PROD_W - QW;
    localparam int CW  = $clog2(QW + 1);

    logic              busy_reg;
    logic              done_reg;
    logic              ovf_reg;
    logic [CW-1:0]     cnt_reg;
    logic [DW-1:0]     rem_reg;
    logic [DW-1:0]     dvs_reg;
    logic [QW-1:0]     sh_reg;

    logic [DW:0]       trial;
    logic              take;
    logic [HW-1:0]     dvd_high;
    logic              too_big;

    assign dvd_high = dividend[tcci_pkg::PROD_W-1:QW];
    // quotient >= 2^QW whenever the top part alone already covers the divisor
    assign too_big  = DW'(dvd_high) >= divisor;

    assign trial = {rem_reg, sh_reg[QW-1]};
    assign take  = trial >= {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            ovf_reg  <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                ovf_reg <= too_big;
                if (too_big)
                begin
                    done_reg <= 1'b1;
                end
                else
                begin
                    busy_reg <= 1'b1;
                    cnt_reg  <= CW'(QW);
                end
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CW'(1);
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // remainder and dividend/quotient shift register
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= DW'(dvd_high);
            dvs_reg <= divisor;
            sh_reg  <= dividend[QW-1:0];
        end
        else if (busy_reg)
        begin
            rem_reg <= take ? DW'(trial - {1'b0, dvs_reg}) : trial[DW-1:0];
            sh_reg  <= {sh_reg[QW-2:0], take};
        end
    end

    assign done     = done_reg;
    assign quotient = (ovf_reg || sh_reg > tcci_pkg::QUOT_CAP) ? tcci_pkg::QUOT_CAP : sh_reg;

endmodule

/* src/temp_compensated_curve_interp_unit.sv */
// ----------------------------------------------------------------------------
// temp_compensated_curve_interp_unit
// Temperature-compensated piecewise-linear lookup over CURVES breakpoint
// curves of TABLE_DEPTH entries, signed Q16.16. One item is worked on at a
// time; the next item is taken while the previous result waits at the
// output. A query walks the key column from entry 0, one key per cycle out
// of the breakpoint memory, until the bracketing segment is found, then
// fetches both breakpoints, forms the temperature adjusted values and the
// products, and runs the bit-serial divider (41 quotient bits; skipped when
// the segment keys are equal) before it hands off the result and returns to
// idle. Queries on a curve that does not exist skip the search and the
// arithmetic. Table entries must be written before a query reads them.
// ----------------------------------------------------------------------------
module temp_compensated_curve_interp_unit #(
    parameter int TABLE_DEPTH = tcci_pkg::DEF_TABLE_DEPTH,
    parameter int CURVES      = tcci_pkg::DEF_CURVES,
    parameter int FRAC_BITS   = tcci_pkg::DEF_FRAC_BITS
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // configuration: last_index
    input  logic                                 cfg_we,
    input  logic [tcci_pkg::LAST_W-1:0]          cfg_wdata,
    // input items
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // entry_index, entry_key, entry_base, entry_slope, query_key, temperature
    input  logic [tcci_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    // operation, curve
    input  logic [tcci_pkg::IN_TUSER_W-1:0]      s_axis_tuser,
    // result items
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // value, segment
    output logic [tcci_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
    // divide_fault
    output logic [tcci_pkg::OUT_TUSER_W-1:0]     m_axis_tuser
);

    localparam int ENTRIES = CURVES * TABLE_DEPTH;
    localparam int AW      = $clog2(ENTRIES);
    localparam int IW      = $clog2(TABLE_DEPTH);
    localparam int VW      = tcci_pkg::VAL_W;
    localparam int MW      = tcci_pkg::MUL_W;
    localparam int PW      = tcci_pkg::PROD_W;

    typedef enum logic [11:0] {
        ST_IDLE   = 12'b000000000001,
        ST_WRITE  = 12'b000000000010,
        ST_SEARCH = 12'b000000000100,
        ST_FETCH0 = 12'b000000001000,
        ST_FETCH1 = 12'b000000010000,
        ST_PV0    = 12'b000000100000,
        ST_PV1    = 12'b000001000000,
        ST_DIFF   = 12'b000010000000,
        ST_MUL    = 12'b000100000000,
        ST_CHK    = 12'b001000000000,
        ST_DIV    = 12'b010000000000,
        ST_DONE   = 12'b100000000000
    } state_t;

    state_t state_reg, state_next;

    // configuration
    logic [tcci_pkg::LAST_W-1:0] last_index_reg;
    logic [IW-1:0]               last_eff;
    logic [IW-1:0]               last_eff_reg;

    // latched item
    logic [tcci_pkg::CURVE_W-1:0] curve_reg;
    logic [tcci_pkg::IDX_W-1:0]   idx_reg;
    tcci_pkg::entry_t             wentry_reg;
    logic signed [VW-1:0]         q_reg;
    logic signed [VW-1:0]         t_reg;

    // search
    logic [IW:0]          srch_idx_reg;
    logic [IW:0]          chk_idx_reg;
    logic                 rd_pend_reg;
    logic signed [VW-1:0] prev_key_reg;
    logic                 srch_issue;
    logic                 srch_hit;
    logic [IW-1:0]        srch_seg;
    logic [IW-1:0]        seg_reg;

    // datapath
    logic signed [VW-1:0] k0_reg, k1_reg;
    logic signed [VW-1:0] base0_reg, base1_reg;
    logic signed [VW-1:0] v0_reg, v1_reg;
    logic signed [MW-1:0] dk_reg, dq_reg, dv_reg;
    logic signed [MW-1:0] mul_a, mul_b;
    logic signed [PW-1:0] prod_reg;
    logic signed [VW-1:0] base_sel;
    logic signed [PW-1:0] pv_sum;
    logic [VW-1:0]        pv_val;
    logic                 neg_reg;
    logic signed [PW-1:0] fin_sum;
    logic [VW-1:0]        value_reg;
    logic                 fault_reg;

    // divider
    logic                             div_start;
    logic                             div_done;
    logic [tcci_pkg::QUOT_W-1:0]      div_quot;
    logic [PW-1:0]                    dvd_mag;
    logic [MW-1:0]                    dvs_mag;

    // memory
    logic                 mem_we;
    logic [AW-1:0]        mem_waddr;
    logic                 mem_re;
    logic [AW-1:0]        mem_raddr;
    tcci_pkg::entry_t     mem_rdata;
    logic [31:0]          off32;

    // output register
    logic                       m_valid_reg;
    logic [VW-1:0]              m_value_reg;
    logic [tcci_pkg::SEG_W-1:0] m_seg_reg;
    logic                       m_fault_reg;

    logic accept;
    logic out_load;
    logic in_curve_ok;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign out_load      = (state_reg == ST_DONE) && (!m_valid_reg || m_axis_tready);
    assign in_curve_ok   = 32'(s_axis_tuser[tcci_pkg::OP_W +: tcci_pkg::CURVE_W]) < CURVES;

    // ---------------- configuration ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_index_reg <= tcci_pkg::LAST_W'(1);
        end
        else if (cfg_we)
        begin
            last_index_reg <= cfg_wdata;
        end
    end

    always_comb
    begin
        if (last_index_reg == '0)
        begin
            last_eff = IW'(1);
        end
        else if (32'(last_index_reg) > TABLE_DEPTH - 1)
        begin
            last_eff = IW'(TABLE_DEPTH - 1);
        end
        else
        begin
            last_eff = IW'(last_index_reg);
        end
    end

    // ---------------- sequencer ----------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (s_axis_tuser[tcci_pkg::OP_W-1:0] == tcci_pkg::OP_WRITE)
                    begin
                        state_next = ST_WRITE;
                    end
                    else if (in_curve_ok)
                    begin
                        state_next = ST_SEARCH;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_WRITE:  state_next = ST_DONE;
            ST_SEARCH:
            begin
                if (srch_hit)
                begin
                    state_next = ST_FETCH0;
                end
            end
            ST_FETCH0: state_next = ST_FETCH1;
            ST_FETCH1: state_next = ST_PV0;
            ST_PV0:    state_next = ST_PV1;
            ST_PV1:    state_next = ST_DIFF;
            ST_DIFF:   state_next = ST_MUL;
            ST_MUL:    state_next = ST_CHK;
            ST_CHK:    state_next = (dk_reg == '0) ? ST_DONE : ST_DIV;
            ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // ---------------- item latch ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_eff_reg <= IW'(1);
        end
        else if (accept)
        begin
            last_eff_reg <= last_eff;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            curve_reg        <= s_axis_tuser[tcci_pkg::OP_W +: tcci_pkg::CURVE_W];
            idx_reg          <= s_axis_tdata[tcci_pkg::IDX_W-1:0];
            wentry_reg.key   <= s_axis_tdata[tcci_pkg::IN_KEY_LSB +: VW];
            wentry_reg.base  <= s_axis_tdata[tcci_pkg::IN_BASE_LSB +: VW];
            wentry_reg.slope <= s_axis_tdata[tcci_pkg::IN_SLOPE_LSB +: VW];
            q_reg            <= s_axis_tdata[tcci_pkg::IN_QKEY_LSB +: VW];
            t_reg            <= s_axis_tdata[tcci_pkg::IN_TEMP_LSB +: VW];
        end
    end

    // ---------------- breakpoint memory ----------------
    assign off32 = 32'(curve_reg) * TABLE_DEPTH;

    assign mem_we    = (state_reg == ST_WRITE) && (32'(curve_reg) < CURVES)
                       && (32'(idx_reg) < TABLE_DEPTH);
    assign mem_waddr = AW'(off32 + 32'(idx_reg));

    assign srch_issue = (state_reg == ST_SEARCH) && (srch_idx_reg <= {1'b0, last_eff_reg});

    always_comb
    begin
        mem_re    = 1'b0;
        mem_raddr = AW'(off32 + 32'(srch_idx_reg));
        if (srch_issue)
        begin
            mem_re = 1'b1;
        end
        else if (state_reg == ST_FETCH0)
        begin
            mem_re    = 1'b1;
            mem_raddr = AW'(off32 + 32'(seg_reg));
        end
        else if (state_reg == ST_FETCH1)
        begin
            mem_re    = 1'b1;
            mem_raddr = AW'(off32 + 32'(seg_reg) + 32'd1);
        end
    end

    tcci_mem #(
        .DEPTH (ENTRIES)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (wentry_reg),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // ---------------- segment search ----------------
    // one key read per cycle; each key is checked in the cycle after its read
    always_comb
    begin
        srch_hit = 1'b0;
        srch_seg = '0;
        if (state_reg == ST_SEARCH && rd_pend_reg)
        begin
            if (chk_idx_reg == '0)
            begin
                srch_hit = (mem_rdata.key >= q_reg);
            end
            else if (prev_key_reg <= q_reg && mem_rdata.key >= q_reg)
            begin
                srch_hit = 1'b1;
                srch_seg = IW'(chk_idx_reg - (IW+1)'(1));
            end
            else if (chk_idx_reg == {1'b0, last_eff_reg})
            begin
                // no bracket: extrapolate on the last segment
                srch_hit = 1'b1;
                srch_seg = last_eff_reg - IW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            srch_idx_reg <= '0;
            chk_idx_reg  <= '0;
            rd_pend_reg  <= 1'b0;
        end
        else if (accept)
        begin
            srch_idx_reg <= '0;
            rd_pend_reg  <= 1'b0;
        end
        else if (state_reg == ST_SEARCH)
        begin
            rd_pend_reg <= srch_issue;
            if (srch_issue)
            begin
                srch_idx_reg <= srch_idx_reg + (IW+1)'(1);
                chk_idx_reg  <= srch_idx_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_SEARCH && rd_pend_reg)
        begin
            prev_key_reg <= mem_rdata.key;
        end
    end

    // ---------------- arithmetic ----------------
    always_comb
    begin
        if (state_reg == ST_MUL)
        begin
            mul_a = dq_reg;
            mul_b = dv_reg;
        end
        else
        begin
            mul_a = MW'(t_reg);
            mul_b = MW'(mem_rdata.slope);
        end
    end

    // base + floor(t * slope / 2^FRAC_BITS)
    assign base_sel = (state_reg == ST_PV0) ? base0_reg : base1_reg;
    assign pv_sum   = PW'(base_sel) + (prod_reg >>> FRAC_BITS);
    assign pv_val   = tcci_pkg::sat32(pv_sum);

    assign fin_sum  = neg_reg ? (PW'(v1_reg) - $signed(PW'(div_quot)))
                              : (PW'(v1_reg) + $signed(PW'(div_quot)));

    assign dvd_mag   = prod_reg[PW-1] ? -prod_reg : prod_reg;
    assign dvs_mag   = dk_reg[MW-1] ? -dk_reg : dk_reg;
    assign div_start = (state_reg == ST_CHK) && (dk_reg != '0);

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_FETCH1 || state_reg == ST_PV0 || state_reg == ST_MUL)
        begin
            prod_reg <= mul_a * mul_b;
        end
        if (state_reg == ST_FETCH1)
        begin
            k0_reg    <= mem_rdata.key;
            base0_reg <= mem_rdata.base;
        end
        if (state_reg == ST_PV0)
        begin
            k1_reg    <= mem_rdata.key;
            base1_reg <= mem_rdata.base;
            v0_reg    <= pv_val;
        end
        if (state_reg == ST_PV1)
        begin
            v1_reg <= pv_val;
        end
        if (state_reg == ST_DIFF)
        begin
            dk_reg <= MW'(k1_reg) - MW'(k0_reg);
            dq_reg <= MW'(q_reg) - MW'(k1_reg);
            dv_reg <= MW'(v1_reg) - MW'(v0_reg);
        end
        if (state_reg == ST_CHK)
        begin
            neg_reg <= prod_reg[PW-1] ^ dk_reg[MW-1];
        end
    end

    // result of the current item
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            value_reg <= '0;
            seg_reg   <= '0;
            fault_reg <= 1'b0;
        end
        else
        begin
            if (srch_hit)
            begin
                seg_reg <= srch_seg;
            end
            if (state_reg == ST_CHK && dk_reg == '0)
            begin
                value_reg <= v1_reg;
                fault_reg <= 1'b1;
            end
            if (state_reg == ST_DIV && div_done)
            begin
                value_reg <= tcci_pkg::sat32(fin_sum);
            end
        end
    end

    tcci_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (dvd_mag),
        .divisor  (dvs_mag),
        .done     (div_done),
        .quotient (div_quot)
    );

    // ---------------- output register ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            m_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            m_value_reg <= value_reg;
            m_seg_reg   <= tcci_pkg::SEG_W'(seg_reg);
            m_fault_reg <= fault_reg;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {{tcci_pkg::OUT_PAD_W{1'b0}}, m_seg_reg, m_value_reg};
    assign m_axis_tuser  = m_fault_reg;

    // ---------------- assertions ----------------
    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg != ST_IDLE))
        else $error("item accepted but sequencer stayed idle");

    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> (dk_reg != '0))
        else $error("divider started with a zero divisor");

    a_quot_capped: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (div_quot <= tcci_pkg::QUOT_CAP))
        else $error("divider quotient above cap");

    a_seg_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE) |-> (seg_reg < last_eff_reg))
        else $error("segment beyond last breakpoint");

endmodule

/* sim/curve_interp_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// curve_interp_checker
// Watches the configuration port and both item channels of the curve
// interpolation unit. Keeps its own breakpoint tables and last index, works
// out the result of every accepted input item and compares it field by field
// with the result items in order.
// ----------------------------------------------------------------------------
module curve_interp_checker (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [tcci_pkg::LAST_W-1:0]          cfg_wdata,
    input  logic                                 s_axis_tvalid,
    input  logic                                 s_axis_tready,
    input  logic [tcci_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    input  logic [tcci_pkg::IN_TUSER_W-1:0]      s_axis_tuser,
    input  logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    input  logic [tcci_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
    input  logic [tcci_pkg::OUT_TUSER_W-1:0]     m_axis_tuser,
    output int                                   fail_count,
    output int                                   outstanding
);

    import tcci_pkg::*;

    localparam int DEPTH       = DEF_TABLE_DEPTH;
    localparam int CURVES      = DEF_CURVES;
    localparam int FRAC_BITS   = DEF_FRAC_BITS;

    typedef struct {
        logic signed [VAL_W-1:0] value;
        logic [SEG_W-1:0]        segment;
        logic                    divide_fault;
    } lookup_result_t;

    entry_t            breakpoints [CURVES*DEPTH];
    lookup_result_t    pending_lookups [$];
    logic [LAST_W-1:0] last_index_shadow = LAST_W'(1);
    int                fails = 0;

    function automatic logic signed [VAL_W-1:0] clamp32(input longint v);
        if (v > 64'sd2147483647)
        begin
            return 32'sh7fff_ffff;
        end
        if (v < -64'sd2147483648)
        begin
            return 32'sh8000_0000;
        end
        return v[VAL_W-1:0];
    endfunction

    function automatic longint key_at(input int addr);
        return longint'(signed'(breakpoints[addr].key));
    endfunction

    // base + floor(t * slope / 2^FRAC_BITS), saturated
    function automatic longint compensated_value(input entry_t e, input longint t);
        longint prod;
        prod = t * longint'(signed'(e.slope));
        return longint'(clamp32(longint'(signed'(e.base)) + (prod >>> FRAC_BITS)));
    endfunction

    function automatic void predict_lookup(input logic [IN_TUSER_W-1:0] user,
                                           input logic [IN_TDATA_W-1:0] data);
        lookup_result_t          r;
        entry_t                  e;
        logic [CURVE_W-1:0]      cv;
        logic [IDX_W-1:0]        idx;
        int                      first;
        int                      last;
        int                      seg;
        bit                      found;
        bit                      neg;
        longint                  q;
        longint                  t;
        longint                  k0;
        longint                  k1;
        longint                  v0;
        longint                  v1;
        longint                  dk;
        longint                  adj;
        logic signed [127:0]     dq_w;
        logic signed [127:0]     dv_w;
        logic signed [127:0]     dk_w;
        logic signed [127:0]     num;
        logic [127:0]            num_mag;
        logic [127:0]            dk_mag;
        logic [127:0]            quo;
        r.value        = '0;
        r.segment      = '0;
        r.divide_fault = 1'b0;
        cv      = user[OP_W +: CURVE_W];
        idx     = data[0 +: IDX_W];
        e.key   = data[IN_KEY_LSB +: VAL_W];
        e.base  = data[IN_BASE_LSB +: VAL_W];
        e.slope = data[IN_SLOPE_LSB +: VAL_W];
        if (user[0 +: OP_W] == OP_WRITE)
        begin
            // writes to a missing curve are dropped
            if (cv < CURVES && idx < DEPTH)
            begin
                breakpoints[cv*DEPTH + idx] = e;
            end
        end
        else if (cv < CURVES)
        begin
            first = cv * DEPTH;
            last  = last_index_shadow;
            if (last < 1)
            begin
                last = 1;
            end
            if (last > DEPTH - 1)
            begin
                last = DEPTH - 1;
            end
            q = longint'(signed'(data[IN_QKEY_LSB +: VAL_W]));
            t = longint'(signed'(data[IN_TEMP_LSB +: VAL_W]));
            if (key_at(first) >= q)
            begin
                seg = 0;
            end
            else
            begin
                // no bracket found: extrapolate along the last segment
                seg   = last - 1;
                found = 1'b0;
                for (int i = 0; i < last; i++)
                begin
                    if (!found && key_at(first + i) <= q && key_at(first + i + 1) >= q)
                    begin
                        seg   = i;
                        found = 1'b1;
                    end
                end
            end
            k0 = key_at(first + seg);
            k1 = key_at(first + seg + 1);
            v0 = compensated_value(breakpoints[first + seg], t);
            v1 = compensated_value(breakpoints[first + seg + 1], t);
            dk = k1 - k0;
            if (dk == 0)
            begin
                r.divide_fault = 1'b1;
                r.value        = clamp32(v1);
            end
            else
            begin
                dq_w    = q - k1;
                dv_w    = v1 - v0;
                dk_w    = dk;
                num     = dq_w * dv_w;
                num_mag = num[127] ? -num : num;
                dk_mag  = dk_w[127] ? -dk_w : dk_w;
                quo     = num_mag / dk_mag;
                if (quo > 128'(QUOT_CAP))
                begin
                    quo = 128'(QUOT_CAP);
                end
                neg     = num[127] ^ dk_w[127];
                adj     = longint'(quo[QUOT_W-1:0]);
                r.value = clamp32(neg ? v1 - adj : v1 + adj);
            end
            r.segment = SEG_W'(seg);
        end
        pending_lookups.push_back(r);
    endfunction

    function automatic void report_mismatch(input string field, input longint expv,
                                            input longint gotv);
        fails++;
        $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, expv, gotv);
    endfunction

    function automatic void check_result(input logic [OUT_TDATA_W-1:0] data,
                                         input logic [OUT_TUSER_W-1:0] user);
        lookup_result_t          want;
        logic signed [VAL_W-1:0] got_value;
        logic [SEG_W-1:0]        got_segment;
        got_value   = data[VAL_W-1:0];
        got_segment = data[VAL_W +: SEG_W];
        if (pending_lookups.size() == 0)
        begin
            fails++;
            $display("%0t: unexpected result item: expected none, actual value %0d",
                     $time, got_value);
            return;
        end
        want = pending_lookups.pop_front();
        if (got_value !== want.value)
        begin
            report_mismatch("value", want.value, got_value);
        end
        if (got_segment !== want.segment)
        begin
            report_mismatch("segment", want.segment, got_segment);
        end
        if (user[0] !== want.divide_fault)
        begin
            report_mismatch("divide_fault", want.divide_fault, user[0]);
        end
    endfunction

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            // results first: a result leaving at this edge is always an older item
            if (m_axis_tvalid && m_axis_tready)
            begin
                check_result(m_axis_tdata, m_axis_tuser);
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                predict_lookup(s_axis_tuser, s_axis_tdata);
            end
            if (cfg_we)
            begin
                last_index_shadow = cfg_wdata;
            end
            outstanding <= pending_lookups.size();
            fail_count  <= fails;
        end
    end

endmodule

/* sim/temp_compensated_curve_interp_unit_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// temp_compensated_curve_interp_unit_test
// Drives breakpoint writes and lookups into the curve interpolation unit:
// a short directed run over the corner cases, then phases at several last
// index settings, each loading ascending curves and mixing queries around
// the keys with rewrites, broken keys and items for the missing curve.
// Both sides idle at random; the result side holds off once for a long time.
// ----------------------------------------------------------------------------
module temp_compensated_curve_interp_unit_test;

    import tcci_pkg::*;

    localparam int DEPTH        = DEF_TABLE_DEPTH;
    localparam int CURVES       = DEF_CURVES;
    localparam int RANDOM_ITEMS = 900;
    localparam int HOLD_AT      = 250;
    localparam int LONG_HOLD    = 600;
    localparam int IDLE_LIMIT   = 200000;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_we = 1'b0;
    logic [LAST_W-1:0]      cfg_wdata = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    // entry_index, entry_key, entry_base, entry_slope, query_key, temperature
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    // operation, curve
    logic [IN_TUSER_W-1:0]  s_axis_tuser = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    // value, segment
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    // divide_fault
    logic [OUT_TUSER_W-1:0] m_axis_tuser;

    int fail_count;
    int outstanding;
    int random_items = 0;
    bit sender_burst = 1'b0;
    int key_shadow [CURVES*DEPTH];

    temp_compensated_curve_interp_unit uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    curve_interp_checker lookup_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .fail_count    (fail_count),
        .outstanding   (outstanding)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    initial
    begin
        #10_000_000;
        $display("Test completed with failures");
        $finish;
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap(input bit burst);
        int r;
        r = $urandom_range(0, 99);
        if (burst || r < 45)
        begin
            return 0;
        end
        if (r < 85)
        begin
            return $urandom_range(1, 3);
        end
        if (r < 97)
        begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    // signed value in about +/- 2^bits, full range now and then
    function automatic int rand_fixed(input int bits);
        if ($urandom_range(0, 9) == 0)
        begin
            return $urandom();
        end
        return int'($urandom_range(0, (1 << (bits + 1)) - 1)) - (1 << bits);
    endfunction

    task automatic push_item(input logic [IN_TUSER_W-1:0] user,
                             input logic [IN_TDATA_W-1:0] data);
        int gap;
        gap = pick_gap(sender_burst);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= data;
        s_axis_tuser  <= user;
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
    endtask

    task automatic send_write(input logic [CURVE_W-1:0] curve, input logic [IDX_W-1:0] idx,
                              input int key, input int base, input int slope);
        logic [IN_TDATA_W-1:0] d;
        d = '0;
        d[0 +: IDX_W]             = idx;
        d[IN_KEY_LSB +: VAL_W]    = key;
        d[IN_BASE_LSB +: VAL_W]   = base;
        d[IN_SLOPE_LSB +: VAL_W]  = slope;
        d[IN_QKEY_LSB +: VAL_W]   = $urandom();
        d[IN_TEMP_LSB +: VAL_W]   = $urandom();
        push_item({curve, OP_WRITE}, d);
        if (curve < CURVES)
        begin
            key_shadow[curve*DEPTH + idx] = key;
            random_items++;
        end
    endtask

    task automatic send_query(input logic [CURVE_W-1:0] curve, input int qkey, input int temp);
        logic [IN_TDATA_W-1:0] d;
        d = '0;
        d[0 +: IDX_W]             = $urandom();
        d[IN_KEY_LSB +: VAL_W]    = $urandom();
        d[IN_BASE_LSB +: VAL_W]   = $urandom();
        d[IN_SLOPE_LSB +: VAL_W]  = $urandom();
        d[IN_QKEY_LSB +: VAL_W]   = qkey;
        d[IN_TEMP_LSB +: VAL_W]   = temp;
        push_item({curve, OP_QUERY}, d);
        random_items++;
    endtask

    task automatic wait_idle(input int limit);
        int n;
        n = 0;
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0 && n < limit)
        begin
            @(posedge clk);
            n++;
        end
    endtask

    // result side
    initial
    begin
        int gap;
        bit long_hold_done;
        long_hold_done = 1'b0;
        @(posedge clk);
        forever
        begin
            if (!long_hold_done && random_items >= HOLD_AT)
            begin
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                long_hold_done = 1'b1;
            end
            else
            begin
                m_axis_tready <= 1'b1;
                if ($urandom_range(0, 9) == 0)
                begin
                    repeat (150) @(posedge clk);
                end
                else
                begin
                    repeat ($urandom_range(1, 24)) @(posedge clk);
                end
                gap = pick_gap(1'b0);
                if (gap > 0)
                begin
                    m_axis_tready <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
        end
    end

    initial
    begin
        int phase;
        int setting;
        int span;
        int n;
        int c;
        int i;
        int k;
        int r;
        int q;
        logic [IDX_W-1:0] idx;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // last index is 1 out of reset
        send_write(0, 0, -32'sh10000, 32'sh10000, 32'sh100);
        send_write(0, 1, 32'sh20000, 32'sh30000, -32'sh200);
        send_query(0, 0, 0);
        send_query(0, 32'sh8000_0000, 32'sh7fff_ffff);
        send_query(0, 32'sh7fff_ffff, 32'sh8000_0000);
        send_query(0, -32'sh10000, 32'sh19_0000);
        send_query(0, 32'sh20000, -32'sh14_0000);
        // equal keys
        send_write(1, 0, 32'sh50000, 32'sh7fff_ffff, 32'sh7fff_ffff);
        send_write(1, 1, 32'sh50000, 32'sh8000_0000, 32'sh8000_0000);
        send_query(1, 0, 32'sh10000);
        send_query(1, 32'sh50000, -32'sh10000);
        // full-scale key span
        send_write(2, 0, 32'sh8000_0000, 0, 0);
        send_write(2, 1, 32'sh7fff_ffff, -1, 1);
        send_query(2, 0, 0);
        send_query(2, 32'sh8000_0000, 32'sh7fff_ffff);
        send_query(2, 32'sh7fff_ffff, 32'sh8000_0000);
        // missing curve
        send_write(3, 63, 32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff);
        send_query(3, 32'sh1234, 32'sh5678);
        send_write(0, 63, -1, -1, -1);
        // one-LSB key step with full-scale swing: quotient hits its cap
        send_write(0, 0, 0, 32'sh8000_0000, 0);
        send_write(0, 1, 1, 32'sh7fff_ffff, 0);
        send_query(0, 32'sh7fff_ffff, 0);
        send_query(0, 32'sh8000_0000, 0);
        send_query(0, 32'sh4000, 32'sh7fff_ffff);

        random_items = 0;
        phase = 0;
        while (random_items < RANDOM_ITEMS)
        begin
            case (phase)
                0: setting = 63;
                1: setting = 0;
                2: setting = 2;
                3: setting = 1;
                4: setting = 9;
                default: setting = $urandom_range(1, 20);
            endcase
            wait_idle(IDLE_LIMIT);
            cfg_we    <= 1'b1;
            cfg_wdata <= LAST_W'(setting);
            @(posedge clk);
            cfg_we    <= 1'b0;
            span = (setting == 0) ? 1 : setting;
            sender_burst = ($urandom_range(0, 4) == 0);

            // load ascending curves, now and then a repeated key
            for (c = 0; c < CURVES; c++)
            begin
                if ($urandom_range(0, 7) == 0)
                begin
                    k = 32'sh8000_0000 + $urandom_range(0, 1 << 16);
                end
                else
                begin
                    k = int'($urandom_range(0, 1 << 30)) - (1 << 29);
                end
                for (i = 0; i <= span; i++)
                begin
                    send_write(c, i, k, rand_fixed(24), rand_fixed(18));
                    r = $urandom_range(0, 15);
                    if (r == 1)
                    begin
                        k = k + $urandom_range(0, 1 << 24);
                    end
                    else if (r != 0)
                    begin
                        k = k + $urandom_range(1, 1 << 20);
                    end
                end
            end

            n = $urandom_range(60, 160);
            while (n > 0 && random_items < RANDOM_ITEMS)
            begin
                n--;
                r = $urandom_range(0, 99);
                c = $urandom_range(0, CURVES - 1);
                if (r < 70)
                begin
                    i = $urandom_range(0, span);
                    case ($urandom_range(0, 5))
                        0: q = key_shadow[c*DEPTH + i];
                        1: q = key_shadow[c*DEPTH + i] + $urandom_range(0, 2) - 1;
                        2: q = key_shadow[c*DEPTH + i] + rand_fixed(20);
                        3: q = key_shadow[c*DEPTH] - $urandom_range(1, 1 << 24);
                        4: q = key_shadow[c*DEPTH + span] + $urandom_range(1, 1 << 24);
                        default: q = $urandom();
                    endcase
                    send_query(c, q, rand_fixed(22));
                end
                else if (r < 88)
                begin
                    idx = $urandom();
                    i = $urandom_range(0, 9);
                    if (i < 6)
                    begin
                        k = key_shadow[c*DEPTH + idx];
                    end
                    else if (i < 8)
                    begin
                        // copy the lower neighbor's key: zero-width segment
                        k = key_shadow[c*DEPTH + ((idx == 0) ? 0 : idx - 1)];
                    end
                    else
                    begin
                        k = $urandom();
                    end
                    send_write(c, idx, k, rand_fixed(24), rand_fixed(18));
                end
                else if (r < 94)
                begin
                    send_query(3, $urandom(), $urandom());
                end
                else
                begin
                    send_write(3, $urandom(), $urandom(), $urandom(), $urandom());
                end
            end
            phase++;
        end

        wait_idle(IDLE_LIMIT);
        repeat (200) @(posedge clk);
        if (fail_count == 0 && outstanding == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
